[hw/rtl/rau_pkg.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Operation codes, status codes and the sequencer states of the execution
// side.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam logic [2:0] MODE_ADD  = 3'd0;
   localparam logic [2:0] MODE_SUB  = 3'd1;
   localparam logic [2:0] MODE_MUL  = 3'd2;
   localparam logic [2:0] MODE_DIV  = 3'd3;
   localparam logic [2:0] MODE_NEG  = 3'd4;
   localparam logic [2:0] MODE_NORM = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_COMB,
      S_GSHIFT,
      S_GODD,
      S_GLOOP,
      S_DIV,
      S_CHECK
   } back_state_type;

endpackage

[hw/rtl/rational_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies, divides, negates or normalizes signed
// fractions and reduces the result to lowest terms.
// ----------------------------------------------------------------------------
//  Channel   Handshake                Payload
//  request   start in, busy out       req_mode, req_a_num/den, req_b_num/den
//  response  rsp_valid out, one cycle rsp_res_num, rsp_res_den, rsp_status
//
// For a zero denominator the response is decided in S_MUL, for a zero result
// in S_COMB; otherwise the binary GCD steps and the bit-serial divider set
// the time to the response. Time spent waiting in the queue adds.
// A two-entry queue lets two more transactions wait while one executes;
// busy is high while that queue is full. Reset is synchronous and clears
// the control state only. The receiver cannot stall the response.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_mode,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   output logic        rsp_valid,
   output logic [31:0] rsp_res_num,
   output logic [30:0] rsp_res_den,
   output logic [1:0]  rsp_status
);

   localparam int EW = 3 + 6 * WIDTH;

   logic [EW-1:0] entry, q_data;
   logic          full, empty, q_pop, push;

   assign busy = full;
   assign push = start && !full;

   rau_front #(.WIDTH(WIDTH), .EW(EW)) u_front (
      .mode  (req_mode),
      .a_num (req_a_num),
      .a_den (req_a_den),
      .b_num (req_b_num),
      .b_den (req_b_den),
      .entry (entry)
   );

   rau_queue #(.DW(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (entry),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (full),
      .empty     (empty)
   );

   rau_back #(.WIDTH(WIDTH), .EW(EW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

endmodule

[hw/rtl/rau_front.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Splits operands into sign and magnitude, detects zero denominators and
// selects the multiplier operand pairs for the requested mode.
// ----------------------------------------------------------------------------
module rau_front
   import rau_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int EW    = 3 + 6 * WIDTH
) (
   input  logic [2:0]    mode,
   input  logic [31:0]   a_num,
   input  logic [31:0]   a_den,
   input  logic [31:0]   b_num,
   input  logic [31:0]   b_den,
   output logic [EW-1:0] entry
);

   logic [WIDTH-1:0] an, ad, bn, bd;
   logic             sa, sb, uses_b, err, ps, qs;
   logic [WIDTH-1:0] m1a, m1b, m2a, m2b, d1, d2;

   // Magnitude of a WIDTH-bit two's complement value; the most negative
   // value maps onto its own bit pattern read as unsigned.
   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   always_comb begin
      an = mag_of(a_num[WIDTH-1:0]);
      ad = mag_of(a_den[WIDTH-1:0]);
      bn = mag_of(b_num[WIDTH-1:0]);
      bd = mag_of(b_den[WIDTH-1:0]);
      sa = a_num[WIDTH-1] ^ a_den[WIDTH-1];
      sb = b_num[WIDTH-1] ^ b_den[WIDTH-1];
      uses_b = (mode == MODE_ADD) || (mode == MODE_SUB) || (mode == MODE_MUL) ||
               (mode == MODE_DIV);
      err = (ad == '0) || (uses_b && bd == '0) || (mode == MODE_DIV && bn == '0);
      m2a = '0;
      m2b = '0;
      unique case (mode)
         MODE_ADD, MODE_SUB: begin
            m1a = an; m1b = bd;
            m2a = bn; m2b = ad;
            d1  = ad; d2  = bd;
            ps  = sa;
            qs  = (mode == MODE_SUB) ? !sb : sb;
         end
         MODE_MUL: begin
            m1a = an; m1b = bn;
            d1  = ad; d2  = bd;
            ps  = sa ^ sb; qs = sa ^ sb;
         end
         MODE_DIV: begin
            m1a = an; m1b = bd;
            d1  = ad; d2  = bn;
            ps  = sa ^ sb; qs = sa ^ sb;
         end
         MODE_NEG: begin
            m1a = an; m1b = WIDTH'(1);
            d1  = ad; d2  = WIDTH'(1);
            ps  = !sa; qs = !sa;
         end
         default: begin
            // Normalize, and the unused codes behave the same way.
            m1a = an; m1b = WIDTH'(1);
            d1  = ad; d2  = WIDTH'(1);
            ps  = sa; qs = sa;
         end
      endcase
      entry = {err, ps, qs, m1a, m1b, m2a, m2b, d1, d2};
   end

endmodule

[hw/rtl/rau_queue.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit queue
// Two-entry first-in first-out buffer between the front end and the
// execution side.
// ----------------------------------------------------------------------------
module rau_queue #(
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [DW-1:0] push_data,
   input  logic          pop,
   output logic [DW-1:0] pop_data,
   output logic          full,
   output logic          empty
);

   logic [DW-1:0] mem_ff [2];
   logic          wptr_ff, rptr_ff;
   logic [1:0]    count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_data;
      end
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop) rptr_ff <= !rptr_ff;
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

[hw/rtl/rau_back.sv]
// ----------------------------------------------------------------------------
// Rational arithmetic unit execution side
// Shared multiplier, sign-magnitude combine, binary GCD and a restoring
// divider that reduces numerator and denominator together.
// ----------------------------------------------------------------------------
module rau_back
   import rau_pkg::*;
#(
   parameter int WIDTH = 32,
   parameter int EW    = 3 + 6 * WIDTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  logic [EW-1:0] q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   output logic [31:0]   rsp_res_num,
   output logic [30:0]   rsp_res_den,
   output logic [1:0]    rsp_status
);

   localparam int PW  = 2 * WIDTH;
   localparam int SHW = $clog2(PW);
   localparam int CW  = $clog2(PW + 1);

   back_state_type   state_ff, state_in;
   logic [EW-1:0]    ent_ff;
   logic [1:0]       mcnt_ff, mcnt_in;
   logic [PW-1:0]    p_ff, p_in, q_ff, q_in, d_ff, d_in;
   logic [PW-1:0]    x_ff, x_in, y_ff, y_in;
   logic [SHW-1:0]   sh_ff, sh_in;
   logic             rs_ff, rs_in;
   logic [PW:0]      rm_ff, rm_in, rd_ff, rd_in;
   logic [PW-1:0]    qm_ff, qm_in, qd_ff, qd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             valid_ff, valid_in;
   logic [31:0]      num_ff, num_in;
   logic [30:0]      den_ff, den_in;
   logic [1:0]       st_ff, st_in;

   logic             err, ps, qs;
   logic [WIDTH-1:0] m1a, m1b, m2a, m2b, d1, d2, opa, opb;
   logic [PW-1:0]    prod, mag, lim;
   logic [PW:0]      tm, td;
   logic [WIDTH-1:0] nw;
   logic             ovf;

   assign {err, ps, qs, m1a, m1b, m2a, m2b, d1, d2} = ent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      if (q_pop) ent_ff <= q_data;
      mcnt_ff <= mcnt_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      d_ff    <= d_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      sh_ff   <= sh_in;
      rs_ff   <= rs_in;
      rm_ff   <= rm_in;
      rd_ff   <= rd_in;
      qm_ff   <= qm_in;
      qd_ff   <= qd_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      st_ff   <= st_in;
   end

   always_comb begin
      state_in = state_ff;
      mcnt_in  = mcnt_ff;
      p_in = p_ff; q_in = q_ff; d_in = d_ff;
      x_in = x_ff; y_in = y_ff;
      sh_in = sh_ff; rs_in = rs_ff;
      rm_in = rm_ff; rd_in = rd_ff; qm_in = qm_ff; qd_in = qd_ff;
      cnt_in = cnt_ff;
      valid_in = 1'b0;
      num_in = num_ff; den_in = den_ff; st_in = st_ff;
      q_pop = 1'b0;

      unique case (mcnt_ff)
         2'd0:    begin opa = m1a; opb = m1b; end
         2'd1:    begin opa = m2a; opb = m2b; end
         default: begin opa = d1;  opb = d2;  end
      endcase
      prod = PW'(opa) * PW'(opb);

      if (ps == qs) mag = p_ff + q_ff;
      else if (p_ff >= q_ff) mag = p_ff - q_ff;
      else mag = q_ff - p_ff;

      tm = {rm_ff[PW-1:0], qm_ff[PW-1]};
      td = {rd_ff[PW-1:0], qd_ff[PW-1]};

      lim = PW'({(WIDTH-1){1'b1}});
      ovf = (qd_ff > lim) || (qm_ff > lim + PW'(rs_ff));
      nw  = rs_ff ? (~qm_ff[WIDTH-1:0] + 1'b1) : qm_ff[WIDTH-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               mcnt_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            if (err) begin
               valid_in = 1'b1;
               num_in = '0; den_in = 31'd1; st_in = ST_ZERO_DEN;
               state_in = S_IDLE;
            end else begin
               unique case (mcnt_ff)
                  2'd0:    p_in = prod;
                  2'd1:    q_in = prod;
                  default: d_in = prod;
               endcase
               mcnt_in = mcnt_ff + 2'd1;
               if (mcnt_ff == 2'd2) state_in = S_COMB;
            end
         end
         S_COMB: begin
            rs_in = (ps == qs || p_ff >= q_ff) ? ps : qs;
            p_in  = mag;
            x_in  = mag;
            y_in  = d_ff;
            sh_in = '0;
            if (mag == '0) begin
               valid_in = 1'b1;
               num_in = '0; den_in = 31'd1; st_in = ST_OK;
               state_in = S_IDLE;
            end else begin
               state_in = S_GSHIFT;
            end
         end
         S_GSHIFT: begin
            // Common factors of two are counted here and divided out later by shifting.
            if (!x_ff[0] && !y_ff[0]) begin
               x_in  = x_ff >> 1;
               y_in  = y_ff >> 1;
               sh_in = sh_ff + 1'b1;
            end else begin
               state_in = S_GODD;
            end
         end
         S_GODD: begin
            if (!x_ff[0]) x_in = x_ff >> 1;
            else state_in = S_GLOOP;
         end
         S_GLOOP: begin
            if (y_ff == '0) begin
               // x now holds the odd part of the divisor; the power of two
               // is removed by shifting both dividends first.
               rm_in = '0; rd_in = '0;
               qm_in = p_ff >> sh_ff;
               qd_in = d_ff >> sh_ff;
               cnt_in = '0;
               state_in = S_DIV;
            end else if (!y_ff[0]) begin
               y_in = y_ff >> 1;
            end else if (x_ff > y_ff) begin
               x_in = y_ff;
               y_in = x_ff - y_ff;
            end else begin
               y_in = y_ff - x_ff;
            end
         end
         S_DIV: begin
            if (tm >= {1'b0, x_ff}) begin
               rm_in = tm - {1'b0, x_ff};
               qm_in = {qm_ff[PW-2:0], 1'b1};
            end else begin
               rm_in = tm;
               qm_in = {qm_ff[PW-2:0], 1'b0};
            end
            if (td >= {1'b0, x_ff}) begin
               rd_in = td - {1'b0, x_ff};
               qd_in = {qd_ff[PW-2:0], 1'b1};
            end else begin
               rd_in = td;
               qd_in = {qd_ff[PW-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(PW - 1)) state_in = S_CHECK;
         end
         S_CHECK: begin
            valid_in = 1'b1;
            if (ovf) begin
               num_in = '0; den_in = 31'd1; st_in = ST_OVERFLOW;
            end else begin
               num_in = 32'($signed(nw));
               den_in = 31'(qd_ff[WIDTH-2:0]);
               st_in  = ST_OK;
            end
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid   = valid_ff;
   assign rsp_res_num = num_ff;
   assign rsp_res_den = den_ff;
   assign rsp_status  = st_ff;

endmodule
